/* rtl/fcc_pkg.sv */
`timescale 1ns / 1ps

package fcc_pkg;

   localparam int BASE_LEVELS    = 8;
   localparam int EXTRA_LEVELS   = 4;
   localparam int LEVELS_PER_FAN = BASE_LEVELS + EXTRA_LEVELS;
   localparam int TABLE_DEPTH    = 2 * LEVELS_PER_FAN;
   localparam int LVL_W          = $clog2(LEVELS_PER_FAN);
   localparam int ADDR_W         = $clog2(TABLE_DEPTH);

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 5;

   localparam logic [15:0] TEMP_TOO_HIGH = 16'h07F0;
   localparam logic [8:0]  KEY_ABOVE_ALL = 9'h100;

   localparam logic [1:0] POLICY_KEEP   = 2'd0;
   localparam logic [1:0] POLICY_MANUAL = 2'd1;
   localparam logic [1:0] POLICY_CURVE  = 2'd2;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_TACH_A = 2'd1,
      MODE_TACH_B = 2'd2,
      MODE_LOAD   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_POLICY_A      = 3'd0,
      REG_POLICY_B      = 3'd1,
      REG_MANUAL_DUTY_A = 3'd2,
      REG_MANUAL_DUTY_B = 3'd3,
      REG_SHORT_CURVE_A = 3'd4,
      REG_SHORT_CURVE_B = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_READ,
      ST_EVAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0][1:0] policy;
      logic [1:0][7:0] manual_duty;
      logic [1:0]      short_curve;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic fan;
      logic lvl_clear;
      logic lvl_inc;
      logic rd;
      logic eval;
      logic apply;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] walk;
      logic       less;
      logic       last;
   } status_type;

endpackage

/* rtl/fcc_regs.sv */
`timescale 1ns / 1ps

module fcc_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fcc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output fcc_pkg::cfg_type                  cfg
);

   fcc_pkg::cfg_type       cfg_ff;
   fcc_pkg::cfg_type       cfg_in;
   fcc_pkg::reg_index_type reg_idx;
   logic                   wr_en;

   assign reg_idx    = fcc_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            fcc_pkg::REG_POLICY_A:      cfg_in.policy[0]      = csr_pwdata[1:0];
            fcc_pkg::REG_POLICY_B:      cfg_in.policy[1]      = csr_pwdata[1:0];
            fcc_pkg::REG_MANUAL_DUTY_A: cfg_in.manual_duty[0] = csr_pwdata[7:0];
            fcc_pkg::REG_MANUAL_DUTY_B: cfg_in.manual_duty[1] = csr_pwdata[7:0];
            fcc_pkg::REG_SHORT_CURVE_A: cfg_in.short_curve[0] = csr_pwdata[0];
            fcc_pkg::REG_SHORT_CURVE_B: cfg_in.short_curve[1] = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         fcc_pkg::REG_POLICY_A:      csr_prdata = {30'd0, cfg_ff.policy[0]};
         fcc_pkg::REG_POLICY_B:      csr_prdata = {30'd0, cfg_ff.policy[1]};
         fcc_pkg::REG_MANUAL_DUTY_A: csr_prdata = {24'd0, cfg_ff.manual_duty[0]};
         fcc_pkg::REG_MANUAL_DUTY_B: csr_prdata = {24'd0, cfg_ff.manual_duty[1]};
         fcc_pkg::REG_SHORT_CURVE_A: csr_prdata = {31'd0, cfg_ff.short_curve[0]};
         fcc_pkg::REG_SHORT_CURVE_B: csr_prdata = {31'd0, cfg_ff.short_curve[1]};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/fcc_ctrl.sv */
`timescale 1ns / 1ps

module fcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  fcc_pkg::status_type  status,
   output fcc_pkg::cmd_type     cmd
);

   fcc_pkg::state_type state_ff;
   fcc_pkg::state_type state_in;
   logic               fan_ff;
   logic               fan_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      fan_in   = fan_ff;
      unique case (state_ff)
         fcc_pkg::ST_IDLE: begin
            fan_in = 1'b0;
            if (req_tvalid) begin
               if (fcc_pkg::mode_type'(req_tuser) == fcc_pkg::MODE_TICK) begin
                  state_in = fcc_pkg::ST_PICK;
               end else begin
                  state_in = fcc_pkg::ST_EMIT;
               end
            end
         end
         fcc_pkg::ST_PICK: begin
            if (status.walk[fan_ff]) begin
               state_in = fcc_pkg::ST_READ;
            end else if (fan_ff) begin
               state_in = fcc_pkg::ST_EMIT;
            end else begin
               fan_in = 1'b1;
            end
         end
         fcc_pkg::ST_READ: begin
            state_in = fcc_pkg::ST_EVAL;
         end
         fcc_pkg::ST_EVAL: begin
            if (status.less | status.last) begin
               if (fan_ff) begin
                  state_in = fcc_pkg::ST_EMIT;
               end else begin
                  fan_in   = 1'b1;
                  state_in = fcc_pkg::ST_PICK;
               end
            end else begin
               state_in = fcc_pkg::ST_READ;
            end
         end
         fcc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = fcc_pkg::ST_IDLE;
            end
         end
         default: state_in = fcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.fan      = fan_ff;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         fcc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         fcc_pkg::ST_PICK: begin
            cmd.lvl_clear = status.walk[fan_ff];
         end
         fcc_pkg::ST_READ: begin
            cmd.rd = 1'b1;
         end
         fcc_pkg::ST_EVAL: begin
            cmd.eval    = 1'b1;
            cmd.apply   = status.less | status.last;
            cmd.lvl_inc = ~(status.less | status.last);
         end
         fcc_pkg::ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcc_pkg::ST_IDLE;
         fan_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fan_ff       <= fan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/fcc_dp.sv */
`timescale 1ns / 1ps

module fcc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  fcc_pkg::cfg_type                  cfg,
   input  fcc_pkg::cmd_type                  cmd,
   output fcc_pkg::status_type               status,
   input  logic [1:0]                        req_tuser,
   input  logic [fcc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic [fcc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic [15:0] req_temp_a;
   logic [15:0] req_temp_b;
   logic        req_hold;
   logic        req_entry_fan;
   logic [3:0]  req_entry_index;
   logic [7:0]  req_entry_bound;
   logic [7:0]  req_entry_duty;
   fcc_pkg::mode_type req_mode;

   assign req_mode        = fcc_pkg::mode_type'(req_tuser);
   assign req_temp_a      = req_tdata[15:0];
   assign req_temp_b      = req_tdata[31:16];
   assign req_hold        = req_tdata[32];
   assign req_entry_fan   = req_tdata[33];
   assign req_entry_index = req_tdata[37:34];
   assign req_entry_bound = req_tdata[45:38];
   assign req_entry_duty  = req_tdata[53:46];

   logic [15:0] curve_mem [fcc_pkg::TABLE_DEPTH];
   logic [15:0] rd_data_ff;

   logic [5:0]            prescale_ff, prescale_in;
   logic [1:0][15:0]      edge_ff, edge_in;
   logic [1:0][15:0]      speed_ff, speed_in;
   logic [1:0][7:0]       duty_ff, duty_in;
   logic [1:0]            walk_ff, walk_in;
   logic                  written_ff, written_in;
   logic [1:0][15:0]      temp_ff, temp_in;
   logic [fcc_pkg::LVL_W-1:0] lvl_ff, lvl_in;
   logic [7:0]            sel_ff, sel_in;
   logic [fcc_pkg::RSP_DATA_W-1:0] out_ff, out_in;

   logic                  window;
   logic                  upd;
   logic                  wr_en;
   logic [fcc_pkg::ADDR_W-1:0] wr_addr;
   logic [fcc_pkg::ADDR_W-1:0] rd_addr;
   logic [15:0]           temp_sel;
   logic                  force_low;
   logic [8:0]            key;
   logic [fcc_pkg::LVL_W-1:0] lvl_last;
   logic                  less;
   logic [7:0]            walk_duty;

   assign window = prescale_ff == 6'd0;
   assign upd    = ~req_hold & (prescale_ff[3:0] == 4'd0);

   assign wr_en   = cmd.accept & (req_mode == fcc_pkg::MODE_LOAD)
                    & (32'(req_entry_index) < fcc_pkg::LEVELS_PER_FAN);
   assign wr_addr = (req_entry_fan ? fcc_pkg::ADDR_W'(fcc_pkg::LEVELS_PER_FAN)
                                   : fcc_pkg::ADDR_W'(0))
                    + fcc_pkg::ADDR_W'(req_entry_index);
   assign rd_addr = (cmd.fan ? fcc_pkg::ADDR_W'(fcc_pkg::LEVELS_PER_FAN)
                             : fcc_pkg::ADDR_W'(0))
                    + fcc_pkg::ADDR_W'(lvl_ff);

   assign temp_sel  = temp_ff[cmd.fan];
   assign force_low = temp_sel[15];
   assign key       = (temp_sel > fcc_pkg::TEMP_TOO_HIGH) ? fcc_pkg::KEY_ABOVE_ALL
                                                          : {1'b0, temp_sel[10:3]};
   assign lvl_last  = cfg.short_curve[cmd.fan]
                      ? fcc_pkg::LVL_W'(fcc_pkg::BASE_LEVELS - 1)
                      : fcc_pkg::LVL_W'(fcc_pkg::LEVELS_PER_FAN - 1);
   assign less      = force_low | (key < {1'b0, rd_data_ff[15:8]});
   assign walk_duty = ((lvl_ff == '0) | ~less) ? rd_data_ff[7:0] : sel_ff;

   assign status.walk = walk_ff;
   assign status.less = less;
   assign status.last = lvl_ff == lvl_last;

   assign rsp_tdata = out_ff;

   always_comb begin
      prescale_in = prescale_ff;
      edge_in     = edge_ff;
      speed_in    = speed_ff;
      duty_in     = duty_ff;
      walk_in     = walk_ff;
      written_in  = written_ff;
      temp_in     = temp_ff;
      lvl_in      = lvl_ff;
      sel_in      = sel_ff;
      out_in      = out_ff;

      if (cmd.accept) begin
         temp_in[0] = req_temp_a;
         temp_in[1] = req_temp_b;
         walk_in    = 2'b00;
         written_in = 1'b0;
         case (req_mode)
            fcc_pkg::MODE_TICK: begin
               if (window) begin
                  speed_in = edge_ff;
                  edge_in  = '0;
               end
               if (upd) begin
                  written_in = 1'b1;
                  for (int f = 0; f < 2; f++) begin
                     if (cfg.policy[f] == fcc_pkg::POLICY_MANUAL) begin
                        duty_in[f] = cfg.manual_duty[f];
                     end
                     walk_in[f] = cfg.policy[f] == fcc_pkg::POLICY_CURVE;
                  end
               end
               prescale_in = prescale_ff + 6'd1;
            end
            fcc_pkg::MODE_TACH_A: edge_in[0] = edge_ff[0] + 16'd1;
            fcc_pkg::MODE_TACH_B: edge_in[1] = edge_ff[1] + 16'd1;
            default: ;
         endcase
      end

      if (cmd.lvl_clear) begin
         lvl_in = '0;
      end
      if (cmd.lvl_inc) begin
         lvl_in = lvl_ff + fcc_pkg::LVL_W'(1);
      end
      if (cmd.eval) begin
         sel_in = walk_duty;
      end
      if (cmd.apply) begin
         duty_in[cmd.fan] = walk_duty;
      end
      if (cmd.emit) begin
         out_in = {7'd0, written_ff, speed_ff[1], speed_ff[0], duty_ff[1], duty_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         edge_ff     <= '0;
         speed_ff    <= '0;
         duty_ff     <= '0;
         walk_ff     <= '0;
         written_ff  <= 1'b0;
      end else begin
         prescale_ff <= prescale_in;
         edge_ff     <= edge_in;
         speed_ff    <= speed_in;
         duty_ff     <= duty_in;
         walk_ff     <= walk_in;
         written_ff  <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
      lvl_ff  <= lvl_in;
      sel_ff  <= sel_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         curve_mem[wr_addr] <= {req_entry_bound, req_entry_duty};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= curve_mem[rd_addr];
      end
   end

endmodule

/* rtl/fan_curve_and_tach_controller.sv */
`timescale 1ns / 1ps

// Two-fan PWM duty controller with tachometer counting.
// Input stream (req_): one beat per event. tuser selects the event: tick,
// fan A tach edge, fan B tach edge, or curve table load. Every beat produces
// exactly one result beat on the rsp_ stream carrying both duties, both
// latched speeds and a flag set when that tick was an unheld update tick.
// Configuration (csr_): APB-style, zero wait states; policies, manual
// duties and curve length per fan. Write only while the block is idle.
// Tach and load beats go from idle straight to the emit state. A tick walks
// the curve levels of each fan on the curve policy (up to 12 per fan): the
// walk reads the shared curve table through its single registered read port,
// one level per read state and evaluate state, fan A first, then fan B.
// One beat is processed at a time; req_tready is high only while the
// sequencer is idle, so a new beat is taken only after the previous result
// has been registered. The result register lets a new beat be accepted
// while the previous result still waits on a stalled receiver; the next
// result is then held until that beat is taken.
// Reset clears counters, speeds, duties, prescaler and configuration registers. The curve
// table is not cleared; load every level in use before selecting the curve.

module fan_curve_and_tach_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode[1:0]
   input  logic [1:0]                        req_tuser,
   // temp_a[15:0], temp_b[31:16], hold[32], entry_fan[33], entry_index[37:34],
   // entry_bound[45:38], entry_duty[53:46], zero[55:54]
   input  logic [fcc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // duty_a[7:0], duty_b[15:8], speed_a[31:16], speed_b[47:32],
   // duty_written[48], zero[55:49]
   output logic [fcc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fcc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   fcc_pkg::cfg_type    cfg;
   fcc_pkg::cmd_type    cmd;
   fcc_pkg::status_type status;

   fcc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fcc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
